>>> src/i2c_master_phase_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// i2c_master_phase_sequencer_unit_defines
// assertion helpers for the i2c phase sequencer
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_PHASE_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_PHASE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define I2CMPS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("i2c phase sequencer check failed");

// next-cycle implication, checked out of reset
`define I2CMPS_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("i2c phase sequencer check failed");

`endif

>>> src/i2cmps_pkg.sv
// ----------------------------------------------------------------------------
// i2cmps_pkg
// types, codes and microcode table of the i2c master phase sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmps_pkg;

    localparam int PC_W = 5;
    localparam logic [15:0] TICKS_RESET = 16'd10;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_WAIT  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6,
        CMD_PROBE = 3'd7
    } t_cmd;

    // scl source
    typedef enum logic [1:0] {
        SCL_LO   = 2'd0,
        SCL_HI   = 2'd1,
        SCL_KEEP = 2'd2
    } t_scl_sel;

    // sda source; DBIT_REL releases after the eighth bit
    typedef enum logic [2:0] {
        SDA_LO       = 3'd0,
        SDA_HI       = 3'd1,
        SDA_KEEP     = 3'd2,
        SDA_DBIT     = 3'd3,
        SDA_DBIT_REL = 3'd4
    } t_sda_sel;

    typedef enum logic [1:0] {
        SMP_NONE = 2'd0,
        SMP_DATA = 2'd1,
        SMP_ACK  = 2'd2
    } t_smp;

    typedef struct packed {
        t_scl_sel          scl_sel;
        t_sda_sel          sda_sel;
        t_smp              smp;
        logic              jmp;     // loop back while bit count not done
        logic [PC_W-1:0]   target;
        logic              fin;     // end of command run
    } t_ctrl;

    localparam logic [PC_W-1:0] PC_START = 5'd0;
    localparam logic [PC_W-1:0] PC_STOP  = 5'd3;
    localparam logic [PC_W-1:0] PC_WRITE = 5'd5;
    localparam logic [PC_W-1:0] PC_READ  = 5'd8;
    localparam logic [PC_W-1:0] PC_WAIT  = 5'd10;
    localparam logic [PC_W-1:0] PC_ACK   = 5'd13;
    localparam logic [PC_W-1:0] PC_NACK  = 5'd17;
    localparam logic [PC_W-1:0] PC_PROBE = 5'd20;
    localparam logic [PC_W-1:0] PC_PWBIT = 5'd23;

    function automatic logic [PC_W-1:0] entry_pc(input t_cmd cmd);
        logic [PC_W-1:0] pc;
        case (cmd)
            CMD_START: pc = PC_START;
            CMD_STOP:  pc = PC_STOP;
            CMD_WRITE: pc = PC_WRITE;
            CMD_READ:  pc = PC_READ;
            CMD_WAIT:  pc = PC_WAIT;
            CMD_ACK:   pc = PC_ACK;
            CMD_NACK:  pc = PC_NACK;
            default:   pc = PC_PROBE;
        endcase
        return pc;
    endfunction

    function automatic t_ctrl mk(input t_scl_sel c, input t_sda_sel d, input t_smp s,
                                 input logic j, input logic [PC_W-1:0] t, input logic f);
        t_ctrl w;
        w.scl_sel = c;
        w.sda_sel = d;
        w.smp     = s;
        w.jmp     = j;
        w.target  = t;
        w.fin     = f;
        return w;
    endfunction

    // microcode table, one control word per bus phase
    function automatic t_ctrl rom_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        case (pc)
            // start
            5'd0:  w = mk(SCL_HI,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd1:  w = mk(SCL_HI,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd2:  w = mk(SCL_LO,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b1);
            // stop
            5'd3:  w = mk(SCL_HI,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd4:  w = mk(SCL_HI,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b1);
            // write byte
            5'd5:  w = mk(SCL_KEEP, SDA_DBIT,     SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd6:  w = mk(SCL_HI,   SDA_DBIT,     SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd7:  w = mk(SCL_LO,   SDA_DBIT_REL, SMP_NONE, 1'b1, PC_WRITE, 1'b1);
            // read byte
            5'd8:  w = mk(SCL_HI,   SDA_KEEP,     SMP_DATA, 1'b0, PC_START, 1'b0);
            5'd9:  w = mk(SCL_LO,   SDA_KEEP,     SMP_NONE, 1'b1, PC_READ,  1'b1);
            // wait ack
            5'd10: w = mk(SCL_KEEP, SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd11: w = mk(SCL_HI,   SDA_HI,       SMP_ACK,  1'b0, PC_START, 1'b0);
            5'd12: w = mk(SCL_LO,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b1);
            // ack
            5'd13: w = mk(SCL_KEEP, SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd14: w = mk(SCL_HI,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd15: w = mk(SCL_LO,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd16: w = mk(SCL_LO,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b1);
            // nack
            5'd17: w = mk(SCL_KEEP, SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd18: w = mk(SCL_HI,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd19: w = mk(SCL_LO,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b1);
            // probe: start, address write, wait ack, stop
            5'd20: w = mk(SCL_HI,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd21: w = mk(SCL_HI,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd22: w = mk(SCL_LO,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd23: w = mk(SCL_KEEP, SDA_DBIT,     SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd24: w = mk(SCL_HI,   SDA_DBIT,     SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd25: w = mk(SCL_LO,   SDA_DBIT_REL, SMP_NONE, 1'b1, PC_PWBIT, 1'b0);
            5'd26: w = mk(SCL_KEEP, SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd27: w = mk(SCL_HI,   SDA_HI,       SMP_ACK,  1'b0, PC_START, 1'b0);
            5'd28: w = mk(SCL_LO,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd29: w = mk(SCL_HI,   SDA_LO,       SMP_NONE, 1'b0, PC_START, 1'b0);
            5'd30: w = mk(SCL_HI,   SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b1);
            default: w = mk(SCL_HI, SDA_HI,       SMP_NONE, 1'b0, PC_START, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/i2c_master_phase_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_phase_sequencer_unit
// bit-banged i2c master that expands bus commands into half-bit phases
// ----------------------------------------------------------------------------
// One request on the slave stream carries a bus command (start, stop, write
// byte, read byte, wait ack, ack, nack, probe). A microcoded sequencer walks a
// 31-word control table and emits one master-stream request per half-bit
// phase: scl level, sda drive level (1 released), sample flag, and on the
// phase marked tlast the read byte and the ack bit (1 = no acknowledge).
// The length of each phase is set by phase_ticks (0 acts as 1): the phase
// is emitted from S_EMIT and the rest of it is held on the hold timer in
// S_HOLD. With the master side ready a command runs 3 phases for start, 2
// for stop, 24 for write, 16 for read, 3 for wait ack and nack, 4 for ack
// and 32 for probe, after it is taken in the idle state. A stalled master
// side stretches a phase until the output register frees. A new command is
// taken once the previous run has finished its last hold; the last phase
// may still wait on the master side at that point.
// Write phase_ticks only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_phase_sequencer_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // configuration: phase_ticks
    input  wire                         i_cfg_wr_en,
    input  wire  [15:0]                 i_cfg_wr_data,
    // command requests
    input  wire                         i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire  [15:0]                 i_s_axis_tdata,  // [7:0] wr_data, [15:8] line_sample
    input  wire  [2:0]                  i_s_axis_tuser,  // [2:0] cmd
    // phase requests
    output logic                        o_m_axis_tvalid,
    input  wire                         i_m_axis_tready,
    output logic [15:0]                 o_m_axis_tdata,  // [0] scl_level, [1] sda_level,
                                                         // [2] sample_point, [10:3] rd_data,
                                                         // [11] ack_bit, [15:12] zero
    output logic                        o_m_axis_tlast   // last phase of the command
);

    import i2cmps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EMIT = 2'd1,
        S_HOLD = 2'd2
    } t_state;

    t_state            r_state;
    logic [15:0]       r_phase_ticks;
    logic [15:0]       r_timer;
    logic [PC_W-1:0]   r_pc;
    logic [2:0]        r_bitcnt;
    logic [7:0]        r_shift;     // outgoing byte, msb is the current bit
    logic [7:0]        r_ls;        // presented sda levels, msb next
    logic              r_ls0;       // level for the acknowledge
    logic [7:0]        r_rd;
    logic              r_ack;
    logic              r_scl;       // bus levels
    logic              r_sda;
    logic              r_fin;

    t_ctrl             w_ctrl;
    logic              w_loop;      // loop jump taken
    logic              w_last;
    logic              n_scl;
    logic              n_sda;
    logic [PC_W-1:0]   n_pc;
    logic [15:0]       w_ticks;
    logic              w_accept;
    logic              w_emit;

    assign w_ctrl   = rom_word(r_pc);
    assign w_loop   = w_ctrl.jmp && (r_bitcnt != 3'd7);
    assign w_last   = w_ctrl.fin && !w_loop;
    assign n_pc     = w_loop ? w_ctrl.target : r_pc + 1'b1;
    assign w_ticks  = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    // a phase goes out once the output register is free
    assign w_emit   = (r_state == S_EMIT) && (!o_m_axis_tvalid || i_m_axis_tready);

    // levels for the phase under the control word
    always_comb begin
        case (w_ctrl.scl_sel)
            SCL_LO:  n_scl = 1'b0;
            SCL_HI:  n_scl = 1'b1;
            default: n_scl = r_scl;
        endcase
        case (w_ctrl.sda_sel)
            SDA_LO:       n_sda = 1'b0;
            SDA_HI:       n_sda = 1'b1;
            SDA_DBIT:     n_sda = r_shift[7];
            SDA_DBIT_REL: n_sda = (r_bitcnt == 3'd7) ? 1'b1 : r_shift[7];
            default:      n_sda = r_sda;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_phase_ticks   <= TICKS_RESET;
            r_timer         <= 16'd1;
            r_pc            <= PC_START;
            r_bitcnt        <= 3'd0;
            r_scl           <= 1'b1;
            r_sda           <= 1'b1;
            r_fin           <= 1'b0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_phase_ticks <= i_cfg_wr_data;
            end
            if (o_m_axis_tvalid && i_m_axis_tready && !w_emit) begin
                o_m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pc     <= entry_pc(t_cmd'(i_s_axis_tuser));
                        r_bitcnt <= 3'd0;
                        // probe sends the address with the write bit
                        r_shift  <= (t_cmd'(i_s_axis_tuser) == CMD_PROBE) ?
                                    (i_s_axis_tdata[7:0] & 8'hFE) : i_s_axis_tdata[7:0];
                        r_ls     <= i_s_axis_tdata[15:8];
                        r_ls0    <= i_s_axis_tdata[8];
                        r_rd     <= 8'd0;
                        r_ack    <= 1'b0;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        o_m_axis_tvalid <= 1'b1;
                        o_m_axis_tdata  <= {4'd0, w_last ? r_ack : 1'b0,
                                            w_last ? r_rd : 8'd0,
                                            (w_ctrl.smp != SMP_NONE), n_sda, n_scl};
                        o_m_axis_tlast  <= w_last;
                        r_scl           <= n_scl;
                        r_sda           <= n_sda;
                        r_pc            <= n_pc;
                        r_fin           <= w_last;
                        r_timer         <= w_ticks - 16'd1;
                        // bit loop: advance count and shift out next bit
                        if (w_ctrl.jmp) begin
                            r_bitcnt <= r_bitcnt + 3'd1;
                            r_shift  <= {r_shift[6:0], 1'b0};
                        end
                        if (w_ctrl.smp == SMP_DATA) begin
                            r_rd <= {r_rd[6:0], r_ls[7]};
                            r_ls <= {r_ls[6:0], 1'b0};
                        end
                        if (w_ctrl.smp == SMP_ACK) begin
                            r_ack <= r_ls0;
                        end
                        // a phase with phase_ticks of 1 (or 0) needs no hold
                        if (w_ticks == 16'd1) begin
                            r_state <= w_last ? S_IDLE : S_EMIT;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    // hold the rest of the phase on the bus
                    if (r_timer <= 16'd1) begin
                        r_state <= r_fin ? S_IDLE : S_EMIT;
                    end else begin
                        r_timer <= r_timer - 16'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "i2c_master_phase_sequencer_unit_defines.svh"

    // hold timer never runs from zero
    `I2CMPS_ASSERT_IMP(a_timer_nonzero, i_clk, i_rst_n, r_state == S_HOLD, r_timer != 16'd0)
    // every bit loop wraps its counter back to zero before the block goes idle
    `I2CMPS_ASSERT_IMP(a_bitcnt_idle, i_clk, i_rst_n, r_state == S_IDLE, r_bitcnt == 3'd0)
    // an accepted command starts emitting phases
    `I2CMPS_ASSERT_NXT(a_accept_emit, i_clk, i_rst_n, w_accept, r_state == S_EMIT)

endmodule

`default_nettype wire
